[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[sv/i2csrm_pkg.sv]
// Types and constants of the I2C slave register map.
package i2csrm_pkg;

   localparam int OP_WIDTH             = 3;
   localparam int CHAN_WIDTH           = 4;
   localparam int SAMPLE_IN_WIDTH      = 10;
   localparam int SAMPLE_WIDTH_DEFAULT = 10;
   localparam int NUM_SAMPLES          = 10;
   localparam int SLOT_WIDTH           = $clog2(NUM_SAMPLES);
   localparam int ADC_VIEW_WIDTH       = 16;

   localparam logic [7:0] REG_DIR       = 8'h01;
   localparam logic [7:0] REG_PORT      = 8'h0F;
   localparam logic [7:0] REG_ADC_FIRST = 8'h10;
   localparam logic [7:0] REG_ADC_LAST  = 8'h23;
   localparam logic [7:0] DIR_RESET     = 8'hFF;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADDR_WR    = 3'd0,
      OP_ADDR_RD    = 3'd1,
      OP_DATA_WR    = 3'd2,
      OP_READ_NEXT  = 3'd3,
      OP_ADC_UPDATE = 3'd4
   } op_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0]        op;
      logic [7:0]                 data_byte;
      logic [CHAN_WIDTH-1:0]      channel;
      logic [SAMPLE_IN_WIDTH-1:0] sample;
      logic [7:0]                 pin_levels;
   } item_type;

   typedef struct packed {
      logic       read_valid;
      logic [7:0] read_byte;
      logic       dir_write;
      logic       port_write;
      logic [7:0] dir_value;
      logic [7:0] port_value;
   } result_type;

   typedef struct packed {
      logic                       en;
      logic [CHAN_WIDTH-1:0]      chan;
      logic [SAMPLE_IN_WIDTH-1:0] sample;
   } adc_wr_type;

endpackage

[sv/i2c_slave_register_map.sv]
// Top level of the I2C slave register map: input and result registers around the core.
//
// Register back end of an I2C slave, fed one byte-level bus event per transaction.
// req_ channel: op (address write/read, data written, read next, ADC update),
//   data_byte, channel, sample and pin_levels, taken when req_valid is high and
//   req_stall is low.
// rsp_ channel: exactly one result transaction per request, in order: read
//   flag and byte, direction/latch write strobes and the current register values.
// Path: a request is held in the input register, then the result register is
//   loaded from the core's combinational decode; rsp_valid rises once the result
//   register holds it.
// Throughput: one transaction per cycle while rsp_stall does not hold a result;
//   the core's pointer and frame state is registered, so back-to-back events see each other's state.
// Stall: when rsp_stall holds a result, the input register keeps its
//   transaction and req_stall rises in the same cycle; nothing is dropped.
// Reset (synchronous, active high): both valids clear, pointer, frame count,
//   decrement flag and latch go to zero, direction to all ones, samples to zero.
module i2c_slave_register_map #(
   parameter int SAMPLE_WIDTH = i2csrm_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [i2csrm_pkg::OP_WIDTH-1:0]        req_op,
   input  logic [7:0]                             req_data_byte,
   input  logic [i2csrm_pkg::CHAN_WIDTH-1:0]      req_channel,
   input  logic [i2csrm_pkg::SAMPLE_IN_WIDTH-1:0] req_sample,
   input  logic [7:0]                             req_pin_levels,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_read_valid,
   output logic [7:0]                             rsp_read_byte,
   output logic                                   rsp_dir_write,
   output logic                                   rsp_port_write,
   output logic [7:0]                             rsp_dir_value,
   output logic [7:0]                             rsp_port_value
);

   // input stage
   logic                   in_valid_ff, in_valid_in;
   i2csrm_pkg::item_type   item_ff, item_in;
   // result stage
   logic                   rsp_valid_ff, rsp_valid_in;
   i2csrm_pkg::result_type rsp_ff, rsp_in;

   logic out_free;   // result register empty or being taken this cycle
   logic step;       // input transaction moves through the core

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign item_in.op         = req_op;
   assign item_in.data_byte  = req_data_byte;
   assign item_in.channel    = req_channel;
   assign item_in.sample     = req_sample;
   assign item_in.pin_levels = req_pin_levels;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = out_free ? in_valid_ff : rsp_valid_ff;

   i2csrm_core #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .result (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= item_in;
      end
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_valid = rsp_ff.read_valid;
   assign rsp_read_byte  = rsp_ff.read_byte;
   assign rsp_dir_write  = rsp_ff.dir_write;
   assign rsp_port_write = rsp_ff.port_write;
   assign rsp_dir_value  = rsp_ff.dir_value;
   assign rsp_port_value = rsp_ff.port_value;

endmodule

[sv/i2csrm_adc_bank.sv]
// Store of the ten ADC samples with one write port and one read port.
module i2csrm_adc_bank #(
   parameter int SAMPLE_WIDTH = i2csrm_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  i2csrm_pkg::adc_wr_type                wr,
   input  logic [i2csrm_pkg::SLOT_WIDTH-1:0]     rd_slot,
   output logic [SAMPLE_WIDTH-1:0]               rd_data
);

   logic [SAMPLE_WIDTH-1:0] samples_ff [i2csrm_pkg::NUM_SAMPLES];
   logic [SAMPLE_WIDTH+i2csrm_pkg::SAMPLE_IN_WIDTH-1:0] wr_ext;
   logic [SAMPLE_WIDTH-1:0] samples_in;
   logic                    wr_hit;

   // zero-extend then cut: drops high bits or pads, whichever the width asks
   assign wr_ext     = {{SAMPLE_WIDTH{1'b0}}, wr.sample};
   assign samples_in = wr_ext[SAMPLE_WIDTH-1:0];
   assign wr_hit     = wr.en &&
                       (wr.chan < i2csrm_pkg::CHAN_WIDTH'(i2csrm_pkg::NUM_SAMPLES));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < i2csrm_pkg::NUM_SAMPLES; i++) begin
            samples_ff[i] <= '0;
         end
      end else if (wr_hit) begin
         samples_ff[wr.chan[i2csrm_pkg::SLOT_WIDTH-1:0]] <= samples_in;
      end
   end

   always_comb begin
      if (rd_slot < i2csrm_pkg::SLOT_WIDTH'(i2csrm_pkg::NUM_SAMPLES)) begin
         rd_data = samples_ff[rd_slot];
      end else begin
         rd_data = '0;
      end
   end

endmodule

[sv/i2csrm_core.sv]
// Register pointer, frame count, port registers and read multiplexer.
module i2csrm_core #(
   parameter int SAMPLE_WIDTH = i2csrm_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  i2csrm_pkg::item_type   item,
   output i2csrm_pkg::result_type result
);

   logic [7:0] ptr_ff, ptr_in;
   logic [7:0] frame_ff, frame_in;
   logic       dec_ff, dec_in;
   logic [7:0] dir_ff, dir_in;
   logic [7:0] latch_ff, latch_in;

   logic [7:0]                          rd_ptr;
   logic [7:0]                          adc_off;
   logic [i2csrm_pkg::SLOT_WIDTH-1:0]   rd_slot;
   logic [SAMPLE_WIDTH-1:0]             rd_sample;
   logic [SAMPLE_WIDTH+i2csrm_pkg::ADC_VIEW_WIDTH-1:0] rd_ext;
   logic [7:0]                          rd_byte;
   i2csrm_pkg::adc_wr_type              adc_wr;

   i2csrm_adc_bank #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_adc_bank (
      .clock   (clock),
      .reset   (reset),
      .wr      (adc_wr),
      .rd_slot (rd_slot),
      .rd_data (rd_sample)
   );

   // an address read sees the pointer after the pending decrement
   assign rd_ptr  = (dec_ff && (item.op == i2csrm_pkg::OP_ADDR_RD)) ? ptr_ff - 8'd1 : ptr_ff;
   assign adc_off = rd_ptr - i2csrm_pkg::REG_ADC_FIRST;
   assign rd_slot = adc_off[i2csrm_pkg::SLOT_WIDTH:1];
   assign rd_ext  = {{i2csrm_pkg::ADC_VIEW_WIDTH{1'b0}}, rd_sample};

   always_comb begin
      if (rd_ptr == i2csrm_pkg::REG_DIR) begin
         rd_byte = dir_ff;
      end else if (rd_ptr == i2csrm_pkg::REG_PORT) begin
         rd_byte = item.pin_levels;
      end else if (rd_ptr inside {[i2csrm_pkg::REG_ADC_FIRST:i2csrm_pkg::REG_ADC_LAST]}) begin
         rd_byte = adc_off[0] ? rd_ext[7:0] : rd_ext[15:8];
      end else begin
         rd_byte = rd_ptr;
      end
   end

   always_comb begin
      ptr_in            = ptr_ff;
      frame_in          = frame_ff;
      dec_in            = dec_ff;
      dir_in            = dir_ff;
      latch_in          = latch_ff;
      result.read_valid = 1'b0;
      result.read_byte  = '0;
      result.dir_write  = 1'b0;
      result.port_write = 1'b0;
      adc_wr.en         = 1'b0;
      adc_wr.chan       = item.channel;
      adc_wr.sample     = item.sample;
      case (i2csrm_pkg::op_type'(item.op))
         i2csrm_pkg::OP_ADDR_WR: begin
            frame_in = '0;
            ptr_in   = rd_ptr;
            dec_in   = 1'b0;
            if (dec_ff) begin
               ptr_in = ptr_ff - 8'd1;
            end
         end
         i2csrm_pkg::OP_ADDR_RD: begin
            frame_in          = '0;
            result.read_valid = 1'b1;
            result.read_byte  = rd_byte;
            ptr_in            = rd_ptr + 8'd1;
            dec_in            = 1'b1;
         end
         i2csrm_pkg::OP_DATA_WR: begin
            frame_in = frame_ff + 8'd1;
            if (frame_in == 8'd1) begin
               ptr_in = item.data_byte;
            end else begin
               if (ptr_ff == i2csrm_pkg::REG_DIR) begin
                  dir_in           = item.data_byte;
                  result.dir_write = 1'b1;
               end else if (ptr_ff == i2csrm_pkg::REG_PORT) begin
                  latch_in          = item.data_byte;
                  result.port_write = 1'b1;
               end
               ptr_in = ptr_ff + 8'd1;
            end
         end
         i2csrm_pkg::OP_READ_NEXT: begin
            frame_in          = frame_ff + 8'd1;
            result.read_valid = 1'b1;
            result.read_byte  = rd_byte;
            ptr_in            = ptr_ff + 8'd1;
            dec_in            = 1'b1;
         end
         i2csrm_pkg::OP_ADC_UPDATE: begin
            adc_wr.en = step;
         end
         default: begin
         end
      endcase
      result.dir_value  = dir_in;
      result.port_value = latch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         frame_ff <= '0;
         dec_ff   <= 1'b0;
         dir_ff   <= i2csrm_pkg::DIR_RESET;
         latch_ff <= '0;
      end else if (step) begin
         ptr_ff   <= ptr_in;
         frame_ff <= frame_in;
         dec_ff   <= dec_in;
         dir_ff   <= dir_in;
         latch_ff <= latch_in;
      end
   end

endmodule

[sv/i2csrm_checker.sv]
// Port-level checks of the I2C slave register map, bound to the top level.
`include "assert_macros.svh"

module i2csrm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_read_valid,
   input logic [7:0] rsp_read_byte,
   input logic       rsp_dir_write,
   input logic       rsp_port_write,
   input logic [7:0] rsp_dir_value
);

   // a stalled result stays offered
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp_valid dropped under stall")

   // no byte without a read
   `ASSERT_NEVER(a_byte_idle, clock, reset, rsp_valid && !rsp_read_valid && (rsp_read_byte != 8'h00), "read byte set without read")

   // one transaction writes at most one register and never also reads
   `ASSERT_NEVER(a_write_excl, clock, reset, rsp_valid && ((rsp_dir_write && rsp_port_write) || ((rsp_dir_write || rsp_port_write) && rsp_read_valid)), "conflicting strobes")

   // direction changes only with a direction write
   `ASSERT_CLK(a_dir_stable, clock, reset, rsp_valid && !rsp_stall ##1 rsp_valid && !rsp_dir_write |-> rsp_dir_value == $past(rsp_dir_value), "direction changed without write")

endmodule

bind i2c_slave_register_map i2csrm_checker u_i2csrm_checker (.*);

[bench/tb.sv]
// Self-checking bench for the I2C slave register map: directed table, then random bus frames.
`timescale 1ns / 1ps

module tb;

   // Spare op codes: the block must treat them as no-ops.
   localparam logic [i2csrm_pkg::OP_WIDTH-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [i2csrm_pkg::OP_WIDTH-1:0] OP_SPARE_LAST  = 3'd7;

   localparam int SAMPLE_BITS      = i2csrm_pkg::SAMPLE_WIDTH_DEFAULT;
   localparam int RANDOM_EVENTS    = 1850;
   localparam int HOLD_OFF_CYCLES  = 50;
   localparam int LONG_FRAME_BYTES = 260;   // enough to wrap the frame byte count
   localparam int DRAIN_CYCLES     = 10;
   localparam int LIMIT_NS         = 5_000_000;

   typedef struct {
      i2csrm_pkg::item_type   ev;
      bit                     typed;   // want was typed in by hand rather than predicted
      i2csrm_pkg::result_type want;
   } bus_row_type;

   logic                                   clock          = 1'b0;
   logic                                   reset          = 1'b1;
   logic                                   req_valid      = 1'b0;
   logic                                   req_stall;
   logic [i2csrm_pkg::OP_WIDTH-1:0]        req_op         = '0;
   logic [7:0]                             req_data_byte  = '0;
   logic [i2csrm_pkg::CHAN_WIDTH-1:0]      req_channel    = '0;
   logic [i2csrm_pkg::SAMPLE_IN_WIDTH-1:0] req_sample     = '0;
   logic [7:0]                             req_pin_levels = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall      = 1'b0;
   logic                                   rsp_read_valid;
   logic [7:0]                             rsp_read_byte;
   logic                                   rsp_dir_write;
   logic                                   rsp_port_write;
   logic [7:0]                             rsp_dir_value;
   logic [7:0]                             rsp_port_value;

   // Predictor state, mirrors the block's register map.
   logic [7:0]             ptr_now           = '0;
   logic [7:0]             frame_count       = '0;
   logic                   pull_back_pending = 1'b0;
   logic [7:0]             dir_now           = i2csrm_pkg::DIR_RESET;
   logic [7:0]             latch_now         = '0;
   logic [SAMPLE_BITS-1:0] adc_store [i2csrm_pkg::NUM_SAMPLES];

   i2csrm_pkg::result_type pending_replies [$];
   bus_row_type            directed_rows [$];

   int  events_sent      = 0;
   int  replies_checked  = 0;
   int  reads_seen       = 0;
   int  dir_writes_seen  = 0;
   int  port_writes_seen = 0;
   int  mismatch_count   = 0;
   bit  sender_quiet     = 1'b0;
   bit  receiver_quiet   = 1'b0;
   bit  hold_off_pending = 1'b0;

   i2c_slave_register_map #(.SAMPLE_WIDTH(SAMPLE_BITS)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_data_byte  (req_data_byte),
      .req_channel    (req_channel),
      .req_sample     (req_sample),
      .req_pin_levels (req_pin_levels),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_valid (rsp_read_valid),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_dir_write  (rsp_dir_write),
      .rsp_port_write (rsp_port_write),
      .rsp_dir_value  (rsp_dir_value),
      .rsp_port_value (rsp_port_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop, well beyond the slowest legal run.
   initial begin
      #(LIMIT_NS);
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor: one bus event in, the reply the block owes for it out. Updates the
   // mirrored register map as a side effect, so it must be called in acceptance order.
   // ---------------------------------------------------------------------------------------
   function automatic i2csrm_pkg::result_type predict_bus_event(i2csrm_pkg::item_type ev);
      i2csrm_pkg::result_type r;
      logic [7:0] offset;
      logic [15:0] wide;
      r = '0;
      // Address phase: new frame, and undo the read-ahead increment of the last read.
      if (ev.op == i2csrm_pkg::OP_ADDR_WR || ev.op == i2csrm_pkg::OP_ADDR_RD) begin
         frame_count = '0;
         if (pull_back_pending) begin
            ptr_now           = ptr_now - 8'd1;
            pull_back_pending = 1'b0;
         end
      end else if (ev.op == i2csrm_pkg::OP_DATA_WR || ev.op == i2csrm_pkg::OP_READ_NEXT) begin
         frame_count = frame_count + 8'd1;   // wraps at 256
      end

      if (ev.op == i2csrm_pkg::OP_ADDR_RD || ev.op == i2csrm_pkg::OP_READ_NEXT) begin
         r.read_valid = 1'b1;
         if (ptr_now == i2csrm_pkg::REG_DIR) begin
            r.read_byte = dir_now;
         end else if (ptr_now == i2csrm_pkg::REG_PORT) begin
            r.read_byte = ev.pin_levels;
         end else if (ptr_now >= i2csrm_pkg::REG_ADC_FIRST &&
                      ptr_now <= i2csrm_pkg::REG_ADC_LAST) begin
            // even offset: high byte (bits 15..8), odd offset: low byte
            offset      = ptr_now - i2csrm_pkg::REG_ADC_FIRST;
            wide        = 16'(adc_store[offset[i2csrm_pkg::SLOT_WIDTH:1]]);
            r.read_byte = offset[0] ? wide[7:0] : wide[15:8];
         end else begin
            r.read_byte = ptr_now;   // unmapped: the pointer reads back
         end
         ptr_now           = ptr_now + 8'd1;
         pull_back_pending = 1'b1;
      end else if (ev.op == i2csrm_pkg::OP_DATA_WR) begin
         if (frame_count == 8'd1) begin
            ptr_now = ev.data_byte;
         end else begin
            if (ptr_now == i2csrm_pkg::REG_DIR) begin
               dir_now     = ev.data_byte;
               r.dir_write = 1'b1;
            end else if (ptr_now == i2csrm_pkg::REG_PORT) begin
               latch_now    = ev.data_byte;
               r.port_write = 1'b1;
            end
            ptr_now = ptr_now + 8'd1;   // discarded bytes still advance the pointer
         end
      end else if (ev.op == i2csrm_pkg::OP_ADC_UPDATE &&
                   ev.channel < i2csrm_pkg::NUM_SAMPLES) begin
         adc_store[ev.channel] = SAMPLE_BITS'(ev.sample);
      end

      r.dir_value  = dir_now;
      r.port_value = latch_now;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------
   function automatic bus_row_type fixed_row(logic [i2csrm_pkg::OP_WIDTH-1:0] op,
                                             logic [7:0] data,
                                             logic [i2csrm_pkg::CHAN_WIDTH-1:0] chan,
                                             logic [i2csrm_pkg::SAMPLE_IN_WIDTH-1:0] smp,
                                             logic [7:0] pins,
                                             i2csrm_pkg::result_type want);
      bus_row_type row;
      row.ev    = '{op, data, chan, smp, pins};
      row.typed = 1'b1;
      row.want  = want;
      return row;
   endfunction

   function automatic bus_row_type predicted_row(logic [i2csrm_pkg::OP_WIDTH-1:0] op,
                                                 logic [7:0] data,
                                                 logic [i2csrm_pkg::CHAN_WIDTH-1:0] chan,
                                                 logic [i2csrm_pkg::SAMPLE_IN_WIDTH-1:0] smp,
                                                 logic [7:0] pins);
      bus_row_type row;
      row       = fixed_row(op, data, chan, smp, pins, '0);
      row.typed = 1'b0;
      return row;
   endfunction

   // Every field random, so all input bits toggle whatever the op.
   function automatic i2csrm_pkg::item_type random_event(logic [i2csrm_pkg::OP_WIDTH-1:0] op);
      i2csrm_pkg::item_type ev;
      ev.op         = op;
      ev.data_byte  = 8'($urandom);
      ev.channel    = i2csrm_pkg::CHAN_WIDTH'($urandom);
      ev.sample     = i2csrm_pkg::SAMPLE_IN_WIDTH'($urandom);
      ev.pin_levels = 8'($urandom);
      return ev;
   endfunction

   // Pointer targets biased towards the mapped registers and the wrap point.
   function automatic logic [7:0] pick_pointer();
      case ($urandom_range(0, 7))
         0:       return i2csrm_pkg::REG_DIR;
         1:       return i2csrm_pkg::REG_PORT;
         2, 3:    return 8'($urandom_range(i2csrm_pkg::REG_ADC_FIRST,
                                           i2csrm_pkg::REG_ADC_LAST));
         4:       return i2csrm_pkg::REG_ADC_LAST + 8'd1;
         5:       return '1;
         default: return 8'($urandom);
      endcase
   endfunction

   // Sender gaps: mostly none or short, now and then long.
   function automatic int sender_gap();
      int r;
      if (sender_quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic int stall_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // One transaction on the req_ channel. The expectation is queued at the accepting
   // edge; the reply cannot come back before the next edge, so ordering is safe.
   task automatic send_event(i2csrm_pkg::item_type ev, bit typed = 1'b0,
                             i2csrm_pkg::result_type want = '0);
      int gap;
      i2csrm_pkg::result_type predicted;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= ev.op;
      req_data_byte  <= ev.data_byte;
      req_channel    <= ev.channel;
      req_sample     <= ev.sample;
      req_pin_levels <= ev.pin_levels;
      do
         @(posedge clock);
      while (req_stall);
      predicted = predict_bus_event(ev);
      pending_replies.push_back(typed ? want : predicted);
      events_sent++;
   endtask

   // Address write then the pointer byte.
   task automatic aim_pointer(logic [7:0] target);
      i2csrm_pkg::item_type ev;
      send_event(random_event(i2csrm_pkg::OP_ADDR_WR));
      ev           = random_event(i2csrm_pkg::OP_DATA_WR);
      ev.data_byte = target;
      send_event(ev);
   endtask

   task automatic wait_for_replies();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_replies.size() != 0);
   endtask

   // Mostly well-formed frames with random payload; the rest ADC updates and noise.
   task automatic random_sequence();
      int kind;
      i2csrm_pkg::item_type ev;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         aim_pointer(pick_pointer());
         repeat ($urandom_range(0, 3)) send_event(random_event(i2csrm_pkg::OP_DATA_WR));
      end else if (kind < 55) begin
         aim_pointer(pick_pointer());
         send_event(random_event(i2csrm_pkg::OP_ADDR_RD));
         repeat ($urandom_range(0, 4)) send_event(random_event(i2csrm_pkg::OP_READ_NEXT));
      end else if (kind < 68) begin
         // repeated read without re-aiming: exercises the pending pull-back
         send_event(random_event(i2csrm_pkg::OP_ADDR_RD));
         repeat ($urandom_range(0, 4)) send_event(random_event(i2csrm_pkg::OP_READ_NEXT));
      end else if (kind < 85) begin
         ev = random_event(i2csrm_pkg::OP_ADC_UPDATE);
         if ($urandom_range(0, 3) != 0)
            ev.channel = i2csrm_pkg::CHAN_WIDTH'($urandom_range(0,
                                                  i2csrm_pkg::NUM_SAMPLES - 1));
         send_event(ev);
      end else begin
         repeat ($urandom_range(1, 4))
            send_event(random_event(i2csrm_pkg::OP_WIDTH'($urandom_range(
                                    i2csrm_pkg::OP_ADDR_WR, OP_SPARE_LAST))));
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Receiver pacing on rsp_stall: short flow/stall bursts, a long hold-off on request,
   // and a stall-free stretch while receiver_quiet is set.
   // ---------------------------------------------------------------------------------------
   initial begin : reply_pacing
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (receiver_quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (stall_len()) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Reply checker: every accepted rsp_ transaction against the oldest expectation.
   // ---------------------------------------------------------------------------------------
   task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : reply_check
      i2csrm_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected reply, expected none, got read %b byte %h",
                     $time, rsp_read_valid, rsp_read_byte);
         end else begin
            want = pending_replies.pop_front();
            compare_field("read_valid", 8'(want.read_valid), 8'(rsp_read_valid));
            compare_field("read_byte",  want.read_byte,      rsp_read_byte);
            compare_field("dir_write",  8'(want.dir_write),  8'(rsp_dir_write));
            compare_field("port_write", 8'(want.port_write), 8'(rsp_port_write));
            compare_field("dir_value",  want.dir_value,      rsp_dir_value);
            compare_field("port_value", want.port_value,     rsp_port_value);
            replies_checked++;
            reads_seen       += int'(rsp_read_valid);
            dir_writes_seen  += int'(rsp_dir_write);
            port_writes_seen += int'(rsp_port_write);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      int  base;
      int  progress;
      bit  drained;
      bit  squeezed;
      bit  long_done;

      foreach (adc_store[k])
         adc_store[k] = '0;
      drained   = 1'b0;
      squeezed  = 1'b0;
      long_done = 1'b0;

      // Directed table. Hand-typed replies where the value is obvious; the rest predicted.
      directed_rows = '{
         // reads straight after reset: pointer 0 reads back, then direction reset value
         fixed_row(i2csrm_pkg::OP_ADDR_RD, 8'h00, 4'h0, 10'h000, 8'h00,
                   '{1'b1, 8'h00, 1'b0, 1'b0, 8'hFF, 8'h00}),
         fixed_row(i2csrm_pkg::OP_READ_NEXT, 8'h00, 4'h0, 10'h000, 8'hAA,
                   '{1'b1, 8'hFF, 1'b0, 1'b0, 8'hFF, 8'h00}),
         // address write pulls the pointer back to 0x01, first byte reloads it
         fixed_row(i2csrm_pkg::OP_ADDR_WR, 8'h00, 4'h0, 10'h000, 8'h00,
                   '{1'b0, 8'h00, 1'b0, 1'b0, 8'hFF, 8'h00}),
         fixed_row(i2csrm_pkg::OP_DATA_WR, i2csrm_pkg::REG_DIR, 4'h0, 10'h000, 8'h00,
                   '{1'b0, 8'h00, 1'b0, 1'b0, 8'hFF, 8'h00}),
         fixed_row(i2csrm_pkg::OP_DATA_WR, 8'h00, 4'h0, 10'h000, 8'h00,
                   '{1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00}),
         // latch write to all ones
         predicted_row(i2csrm_pkg::OP_ADDR_WR, 8'h00, 4'h0, 10'h000, 8'h00),
         predicted_row(i2csrm_pkg::OP_DATA_WR, i2csrm_pkg::REG_PORT, 4'h0, 10'h000, 8'h00),
         fixed_row(i2csrm_pkg::OP_DATA_WR, 8'hFF, 4'h0, 10'h000, 8'h00,
                   '{1'b0, 8'h00, 1'b0, 1'b1, 8'h00, 8'hFF}),
         // samples: first slot at full scale, last slot at 0x2A5, out-of-range slot ignored
         predicted_row(i2csrm_pkg::OP_ADC_UPDATE, 8'h00, 4'h0, 10'h3FF, 8'h00),
         predicted_row(i2csrm_pkg::OP_ADC_UPDATE, 8'h00, 4'h9, 10'h2A5, 8'h00),
         predicted_row(i2csrm_pkg::OP_ADC_UPDATE, 8'h00, 4'hF, 10'h155, 8'h00),
         // read slot 0 high and low
         predicted_row(i2csrm_pkg::OP_ADDR_WR, 8'h00, 4'h0, 10'h000, 8'h00),
         predicted_row(i2csrm_pkg::OP_DATA_WR, i2csrm_pkg::REG_ADC_FIRST, 4'h0, 10'h000,
                       8'h00),
         fixed_row(i2csrm_pkg::OP_ADDR_RD, 8'h00, 4'h0, 10'h000, 8'h00,
                   '{1'b1, 8'h03, 1'b0, 1'b0, 8'h00, 8'hFF}),
         fixed_row(i2csrm_pkg::OP_READ_NEXT, 8'h00, 4'h0, 10'h000, 8'h00,
                   '{1'b1, 8'hFF, 1'b0, 1'b0, 8'h00, 8'hFF}),
         // read slot 9, then one past the ADC window (pointer reads back)
         predicted_row(i2csrm_pkg::OP_ADDR_WR, 8'h00, 4'h0, 10'h000, 8'h00),
         predicted_row(i2csrm_pkg::OP_DATA_WR, i2csrm_pkg::REG_ADC_LAST - 8'd1, 4'h0,
                       10'h000, 8'h00),
         fixed_row(i2csrm_pkg::OP_ADDR_RD, 8'h00, 4'h0, 10'h000, 8'h00,
                   '{1'b1, 8'h02, 1'b0, 1'b0, 8'h00, 8'hFF}),
         fixed_row(i2csrm_pkg::OP_READ_NEXT, 8'h00, 4'h0, 10'h000, 8'h00,
                   '{1'b1, 8'hA5, 1'b0, 1'b0, 8'h00, 8'hFF}),
         predicted_row(i2csrm_pkg::OP_READ_NEXT, 8'h00, 4'h0, 10'h000, 8'h00),
         // spare op codes with every field at its maximum: no effect at all
         fixed_row(OP_SPARE_FIRST, 8'hFF, 4'hF, 10'h3FF, 8'hFF,
                   '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 8'hFF}),
         predicted_row(OP_SPARE_LAST, 8'hFF, 4'hF, 10'h3FF, 8'hFF),
         // pin levels come back on a latch read
         predicted_row(i2csrm_pkg::OP_ADDR_WR, 8'h00, 4'h0, 10'h000, 8'h00),
         predicted_row(i2csrm_pkg::OP_DATA_WR, i2csrm_pkg::REG_PORT, 4'h0, 10'h000, 8'h00),
         fixed_row(i2csrm_pkg::OP_ADDR_RD, 8'h00, 4'h0, 10'h000, 8'h5A,
                   '{1'b1, 8'h5A, 1'b0, 1'b0, 8'h00, 8'hFF})
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

      // Random part, with a few scripted phases along the way.
      base = events_sent;
      while (events_sent - base < RANDOM_EVENTS) begin
         progress = events_sent - base;
         if (progress >= 500 && !drained) begin
            // sender stands still until the pipeline is empty
            drained = 1'b1;
            wait_for_replies();
         end
         if (progress >= 800 && !squeezed) begin
            // receiver holds off while the sender keeps offering back to back
            squeezed         = 1'b1;
            hold_off_pending = 1'b1;
         end
         if (progress >= 1500 && !long_done) begin
            // one frame long enough to wrap the byte count and reload the pointer
            long_done = 1'b1;
            send_event(random_event(i2csrm_pkg::OP_ADDR_WR));
            repeat (LONG_FRAME_BYTES) send_event(random_event(i2csrm_pkg::OP_DATA_WR));
         end
         sender_quiet   = (progress >= 800 && progress < 900) ||
                          (progress >= 1200 && progress < 1350);
         receiver_quiet = progress >= 1200 && progress < 1350;
         random_sequence();
      end
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;

      wait_for_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d bus events (%0d from the directed table) and %0d replies:",
               events_sent, directed_rows.size(), replies_checked);
      $display("  %0d reads, %0d direction writes, %0d latch writes.",
               reads_seen, dir_writes_seen, port_writes_seen);
      if (mismatch_count == 0 && pending_replies.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
